FILE: rtl/nqb_pkg.sv
// nqb_pkg: shared types for the N-queens backtracking solver.
// Holds the sequencer state type and the occupancy mark operation codes.
// No dependencies.
package nqb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BACK,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_EXH
  } state_t;

  typedef enum logic [1:0] {
    MARK_HOLD,
    MARK_SET,
    MARK_CLR,
    MARK_WIPE
  } mark_op_t;

endpackage

FILE: rtl/n_queens_backtrack_solver_top.sv
// n_queens_backtrack_solver_top: search sequencer, placement memory and
// result register of the N-queens solver. Depends on nqb_pkg, nqb_marks.
//
//  channel | signals                                   | moves
//  in      | in_valid, in_ready, restart               | request item
//  out     | out_valid, out_ready, row_number,         | one item per column,
//          |   last_of_solution, exhausted             |   or one exhausted item
//  cfg     | cfg_valid, cfg_ready, board_size          | board size write
//
// Each square trial is one use of the shared free test; a step back reads
// placement memory, then unmarks. Emitting reads each column, then loads
// the output register. Time to a solution is data dependent.
// rst is synchronous: board size 8, marks clear, no search running.
// in_ready and cfg_ready are high only while the sequencer is idle, and
// in_ready also drops while a board size write is offered; a stalled result
// is held in the output register.
module n_queens_backtrack_solver_top #(
  parameter int MAX_BOARD = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] row_number,
  output logic       last_of_solution,
  output logic       exhausted,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] board_size
);

  localparam int CW = $clog2(MAX_BOARD + 1);
  localparam int RW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;

  nqb_pkg::state_t   state, state_next;
  nqb_pkg::mark_op_t op;

  logic [4:0]    bsize;
  logic [4:0]    bs_clamp;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] col, col_next;
  logic [CW-1:0] row, row_next;
  logic [CW-1:0] ecol, ecol_next;
  logic [CW-1:0] mcol, mrow;
  logic          done, done_next;
  logic          free;

  logic [RW-1:0] chosen [MAX_BOARD];
  logic [RW-1:0] rdata;
  logic          rd_en, we;
  logic [RW-1:0] rd_addr, waddr, wdata;

  logic          in_fire, cfg_fire, out_free, load;
  logic [4:0]    load_row;
  logic          load_last, load_exh;
  logic          emit_last;

  assign in_ready  = (state == nqb_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == nqb_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;
  assign emit_last = (ecol == n - CW'(1));

  always_comb begin
    bs_clamp = bsize;
    if (bsize == 5'd0) begin
      bs_clamp = 5'd1;
    end else if (bsize > 5'(MAX_BOARD)) begin
      bs_clamp = 5'(MAX_BOARD);
    end
  end
  assign n_eff = CW'(bs_clamp);

  nqb_marks #(
    .MAX_BOARD(MAX_BOARD)
  ) u_marks (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .n   (n),
    .col (mcol),
    .row (mrow),
    .free(free)
  );

  always_comb begin
    state_next = state;
    op         = nqb_pkg::MARK_HOLD;
    n_next     = n;
    col_next   = col;
    row_next   = row;
    ecol_next  = ecol;
    done_next  = done;
    mcol       = col;
    mrow       = row;
    rd_en      = 1'b0;
    rd_addr    = col[RW-1:0];
    we         = 1'b0;
    waddr      = col[RW-1:0];
    wdata      = row[RW-1:0];
    load       = 1'b0;
    load_row   = 5'd0;
    load_last  = 1'b0;
    load_exh   = 1'b0;
    unique case (state)
      nqb_pkg::ST_IDLE: begin
        if (in_fire) begin
          n_next = n_eff;
          if (restart) begin
            op         = nqb_pkg::MARK_WIPE;
            col_next   = '0;
            row_next   = '0;
            done_next  = 1'b0;
            state_next = nqb_pkg::ST_SEARCH;
          end else if (done) begin
            state_next = nqb_pkg::ST_EXH;
          end else begin
            col_next   = n_eff - CW'(1);
            rd_en      = 1'b1;
            rd_addr    = RW'(n_eff - CW'(1));
            state_next = nqb_pkg::ST_BACK;
          end
        end else if (cfg_fire) begin
          op        = nqb_pkg::MARK_WIPE;
          col_next  = '0;
          done_next = 1'b1;
        end
      end
      nqb_pkg::ST_SEARCH: begin
        if (col == n) begin
          ecol_next  = '0;
          state_next = nqb_pkg::ST_EMIT_RD;
        end else if (row < n) begin
          if (free) begin
            op       = nqb_pkg::MARK_SET;
            we       = 1'b1;
            col_next = col + CW'(1);
            row_next = '0;
          end else begin
            row_next = row + CW'(1);
          end
        end else if (col == '0) begin
          op         = nqb_pkg::MARK_WIPE;
          done_next  = 1'b1;
          state_next = nqb_pkg::ST_EXH;
        end else begin
          col_next   = col - CW'(1);
          rd_en      = 1'b1;
          rd_addr    = RW'(col - CW'(1));
          state_next = nqb_pkg::ST_BACK;
        end
      end
      nqb_pkg::ST_BACK: begin
        mrow       = CW'(rdata);
        op         = nqb_pkg::MARK_CLR;
        row_next   = CW'(rdata) + CW'(1);
        state_next = nqb_pkg::ST_SEARCH;
      end
      nqb_pkg::ST_EMIT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = ecol[RW-1:0];
        state_next = nqb_pkg::ST_EMIT_WR;
      end
      nqb_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          load      = 1'b1;
          load_row  = 5'(rdata) + 5'd1;
          load_last = emit_last;
          if (emit_last) begin
            state_next = nqb_pkg::ST_IDLE;
          end else begin
            ecol_next  = ecol + CW'(1);
            state_next = nqb_pkg::ST_EMIT_RD;
          end
        end
      end
      nqb_pkg::ST_EXH: begin
        if (out_free) begin
          load       = 1'b1;
          load_exh   = 1'b1;
          state_next = nqb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nqb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nqb_pkg::ST_IDLE;
      bsize <= 5'd8;
      n     <= CW'(1);
      col   <= '0;
      row   <= '0;
      ecol  <= '0;
      done  <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        bsize <= board_size;
      end
      n    <= n_next;
      col  <= col_next;
      row  <= row_next;
      ecol <= ecol_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      chosen[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= chosen[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_number       <= load_row;
      last_of_solution <= load_last;
      exhausted        <= load_exh;
    end
  end

  a_cont_done_exh: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !restart && done) |=> (state == nqb_pkg::ST_EXH))
    else $error("continue without a running search did not flag exhaustion");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == nqb_pkg::ST_SEARCH) |-> (col <= n))
    else $error("search column beyond board size");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |=> (state == nqb_pkg::ST_IDLE) && out_valid && last_of_solution)
    else $error("final column item did not end the solution");

  a_exh_stops: assert property (@(posedge clk) disable iff (rst)
    (load && load_exh) |=> done && (row_number == 5'd0))
    else $error("exhausted item left the search running");

endmodule

FILE: rtl/nqb_marks.sv
// nqb_marks: row, up-diagonal and down-diagonal occupancy marks with the
// shared free test for one (column, row) square. Depends on nqb_pkg.
module nqb_marks #(
  parameter int MAX_BOARD = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  nqb_pkg::mark_op_t                 op,
  input  logic [$clog2(MAX_BOARD + 1)-1:0]  n,
  input  logic [$clog2(MAX_BOARD + 1)-1:0]  col,
  input  logic [$clog2(MAX_BOARD + 1)-1:0]  row,
  output logic                              free
);

  localparam int RW   = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
  localparam int DIAG = 2 * MAX_BOARD - 1;
  localparam int DW   = (DIAG > 1) ? $clog2(DIAG) : 1;

  logic [MAX_BOARD-1:0] row_taken;
  logic [DIAG-1:0]      up_taken;
  logic [DIAG-1:0]      down_taken;
  logic [RW-1:0]        ridx;
  logic [DW-1:0]        uidx;
  logic [DW-1:0]        didx;

  assign ridx = row[RW-1:0];
  assign uidx = DW'(col) + DW'(row);
  assign didx = DW'(n) - DW'(1) + DW'(col) - DW'(row);
  assign free = !row_taken[ridx] && !up_taken[uidx] && !down_taken[didx];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_taken  <= '0;
      up_taken   <= '0;
      down_taken <= '0;
    end else begin
      case (op)
        nqb_pkg::MARK_SET: begin
          row_taken[ridx]  <= 1'b1;
          up_taken[uidx]   <= 1'b1;
          down_taken[didx] <= 1'b1;
        end
        nqb_pkg::MARK_CLR: begin
          row_taken[ridx]  <= 1'b0;
          up_taken[uidx]   <= 1'b0;
          down_taken[didx] <= 1'b0;
        end
        nqb_pkg::MARK_WIPE: begin
          row_taken  <= '0;
          up_taken   <= '0;
          down_taken <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for the N-queens backtracking solver top level.
// Mirrors the search in the bench and checks every column item in order.
// Depends on n_queens_backtrack_solver_top (and through it on nqb_pkg).
module tb_top;

  typedef struct packed {
    logic [4:0] row;
    logic       last;
    logic       exhausted;
  } column_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       restart = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] row_number;
  logic       last_of_solution;
  logic       exhausted;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] board_size = 5'd0;

  logic         request_queue [$];
  column_item_t expected_columns [$];
  int unsigned  items_queued = 0;
  int unsigned  items_taken = 0;
  int unsigned  errors = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  logic         hold_req = 1'b0;
  int unsigned  hold_left = 0;

  logic [4:0]  size_reg;
  logic [15:0] rows_used;
  logic [30:0] up_used;
  logic [30:0] down_used;
  logic [3:0]  queen_row [16];
  logic        search_idle;

  n_queens_backtrack_solver_top #(
    .MAX_BOARD(16)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .row_number       (row_number),
    .last_of_solution (last_of_solution),
    .exhausted        (exhausted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .board_size       (board_size)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned size_used();
    int unsigned n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic void wipe_marks();
    rows_used = '0;
    up_used   = '0;
    down_used = '0;
  endfunction

  function automatic void mark_queen(int unsigned n, int unsigned col, int unsigned row,
                                     bit on);
    rows_used[row]           = on;
    up_used[col + row]       = on;
    down_used[n - 1 + col - row] = on;
  endfunction

  function automatic bit square_free(int unsigned n, int unsigned col, int unsigned row);
    return !rows_used[row] && !up_used[col + row] && !down_used[n - 1 + col - row];
  endfunction

  function automatic bit place_queens(int unsigned n, int unsigned col, int unsigned row);
    while (1) begin
      if (col >= n) return 1'b1;
      while (row < n && !square_free(n, col, row)) row++;
      if (row < n) begin
        mark_queen(n, col, row, 1'b1);
        queen_row[col] = row[3:0];
        col++;
        row = 0;
      end else begin
        if (col == 0) begin
          wipe_marks();
          return 1'b0;
        end
        col--;
        row = queen_row[col];
        mark_queen(n, col, row, 1'b0);
        row++;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_solution(logic restart_bit);
    int unsigned  n;
    int unsigned  col;
    bit           found;
    column_item_t item;
    n = size_used();
    found = 1'b0;
    if (restart_bit) begin
      wipe_marks();
      search_idle = 1'b0;
      found = place_queens(n, 0, 0);
    end else if (!search_idle) begin
      col = n - 1;
      mark_queen(n, col, queen_row[col], 1'b0);
      found = place_queens(n, col, queen_row[col] + 1);
    end
    if (!found) begin
      search_idle = 1'b1;
      item = '{row: 5'd0, last: 1'b0, exhausted: 1'b1};
      expected_columns.insert(expected_columns.size(), item);
    end else begin
      for (int unsigned c = 0; c < n; c++) begin
        item = '{row: 5'(queen_row[c]) + 5'd1, last: (c + 1 == n), exhausted: 1'b0};
        expected_columns.insert(expected_columns.size(), item);
      end
    end
  endfunction

  function automatic void apply_board_size(logic [4:0] value);
    size_reg = value;
    wipe_marks();
    search_idle = 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns MISMATCH %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        items_taken++;
        predict_solution(restart);
      end
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          restart  <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    column_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_columns.size() == 0) begin
          report_mismatch($sformatf("item with nothing pending: row %0d last %0b exhausted %0b",
                                    row_number, last_of_solution, exhausted));
        end else begin
          want = expected_columns.pop_front();
          if (row_number !== want.row)
            report_mismatch($sformatf("row_number got %0d want %0d", row_number, want.row));
          if (last_of_solution !== want.last)
            report_mismatch($sformatf("last_of_solution got %0b want %0b",
                                      last_of_solution, want.last));
          if (exhausted !== want.exhausted)
            report_mismatch($sformatf("exhausted got %0b want %0b", exhausted, want.exhausted));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= 600;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic queue_request(input logic restart_bit);
    request_queue.insert(request_queue.size(), restart_bit);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || expected_columns.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_board_size(input logic [4:0] value);
    wait_drained();
    cfg_valid  <= 1'b1;
    board_size <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_board_size(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_episode(input int unsigned phase);
    logic [4:0]  size_code;
    int unsigned n;
    int unsigned continues;
    if ($urandom_range(99) < 70) size_code = 5'($urandom_range(10));
    else size_code = 5'($urandom_range(15, 11));
    write_board_size(size_code);
    n = size_used();
    if ($urandom_range(4) == 0) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 12 : 0;
    end
    if ($urandom_range(9) == 0) queue_request(1'b0);
    queue_request(1'b1);
    if (n <= 6) continues = $urandom_range(12, 1);
    else if (n == 7 && $urandom_range(7) == 0) continues = 42;
    else continues = $urandom_range(8, 1);
    repeat (continues) queue_request($urandom_range(19) == 0);
  endtask

  initial begin
    int unsigned target;
    size_reg = 5'd8;
    wipe_marks();
    search_idle = 1'b1;
    foreach (queen_row[i]) queen_row[i] = 4'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset board size, then edge sizes, aborts and empty boards
    queue_request(1'b0);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    write_board_size(5'd1);
    queue_request(1'b1);
    queue_request(1'b0);
    write_board_size(5'd0);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    write_board_size(5'd2);
    queue_request(1'b1);
    queue_request(1'b0);
    write_board_size(5'd3);
    queue_request(1'b1);
    write_board_size(5'd4);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    write_board_size(5'd5);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b1);
    write_board_size(5'd31);
    queue_request(1'b1);
    queue_request(1'b0);
    write_board_size(5'd16);
    queue_request(1'b0);

    for (int unsigned phase = 0; phase < 3; phase++) begin
      target = items_queued + 97;
      if (phase == 2) begin
        write_board_size(5'd6);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        queue_request(1'b1);
        repeat (5) queue_request(1'b0);
      end
      while (items_queued < target) random_episode(phase);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
